### rtl/core/rra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rra_pkg;

	// field widths
	localparam int CMD_W  = 2;
	localparam int IDX_W  = 8;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 9;

	// bitmap padding and group search geometry
	localparam int PAD_W   = 256;
	localparam int GROUP_W = 16;
	localparam int GROUPS  = PAD_W / GROUP_W;
	localparam int SEL_W   = 4;

	// command codes
	localparam logic [CMD_W-1:0] CMD_REQUEST  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FAIL     = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	// reset value of the unit count register
	localparam logic [CNT_W-1:0] UNIT_COUNT_RST = 9'd256;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic sum;
		logic pick;
		logic finish;
	} ctl_t;

	// lowest set bit of a 16 bit group
	function automatic logic [SEL_W-1:0] first_set(input logic [GROUP_W-1:0] v);
		logic [SEL_W-1:0] r;
		r = '0;
		for (int i = GROUP_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = SEL_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/rra_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rra_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	output logic               result_strobe,
	output rra_pkg::ctl_t      ctl
);
	import rra_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SUM,
		S_PICK,
		S_FIN
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   strobe_q;

	// sequencer: accept, group sums, group pick, finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			busy_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SUM;
						busy_q  <= 1'b1;
					end
				end
				S_SUM: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q  <= S_IDLE;
					busy_q   <= 1'b0;
					strobe_q <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// datapath commands
	always_comb begin
		ctl.load   = start && !busy_q;
		ctl.sum    = (state_q == S_SUM);
		ctl.pick   = (state_q == S_PICK);
		ctl.finish = (state_q == S_FIN);
	end

	assign busy          = busy_q;
	assign result_strobe = strobe_q;

endmodule

`default_nettype wire

### rtl/core/rra_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rra_datapath #(
	parameter int DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rra_pkg::ctl_t                 ctl,
	input  wire logic [rra_pkg::CMD_W-1:0]     command,
	input  wire logic [rra_pkg::IDX_W-1:0]     unit_index,
	input  wire logic                          cfg_wr_en,
	input  wire logic [rra_pkg::CNT_W-1:0]     cfg_wr_data,
	output logic      [rra_pkg::STAT_W-1:0]    status,
	output logic      [rra_pkg::IDX_W-1:0]     granted_index,
	output logic      [rra_pkg::CNT_W-1:0]     done_count,
	output logic                               all_done
);
	import rra_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	// architectural state
	logic [CNT_W-1:0]  unit_count_q;
	logic [DEPTH-1:0]  done_map_q;
	logic [DEPTH-1:0]  busy_map_q;
	logic [IW-1:0]     ptr_q;
	logic [CNT_W-1:0]  done_total_q;

	// per word registers
	logic [CMD_W-1:0]  cmd_q;
	logic [STAT_W-1:0] mark_status_q;
	logic [GROUPS-1:0] any_hi_s1;
	logic [GROUPS-1:0] any_all_s1;
	logic [GROUPS-1:0] grp_done_s1;
	logic [SEL_W-1:0]  grp_s2;
	logic              use_hi_s2;
	logic              found_s2;
	logic              all_done_s2;
	logic [STAT_W-1:0] status_q;
	logic [IDX_W-1:0]  granted_q;
	logic [CNT_W-1:0]  done_count_q;
	logic              all_done_q;

	// combinational
	logic [CNT_W-1:0]  n_eff;
	logic [IW-1:0]     start_ptr;
	logic [PAD_W-1:0]  avail;
	logic [PAD_W-1:0]  avail_hi;
	logic [PAD_W-1:0]  done_mask;
	logic [GROUPS-1:0] any_hi;
	logic [GROUPS-1:0] any_all;
	logic [GROUPS-1:0] grp_done;
	logic              use_hi;
	logic [GROUPS-1:0] grp_vec;
	logic [PAD_W-1:0]  sel_vec;
	logic [GROUP_W-1:0] sel_bits;
	logic [SEL_W-1:0]  bit_sel;
	logic [IDX_W-1:0]  unit_full;
	logic [IW-1:0]     unit_sel;
	logic [CNT_W-1:0]  unit_next;
	logic [IW-1:0]     ptr_next;
	logic              mark_cmd;
	logic              idx_ok;
	logic [IW-1:0]     mark_idx;
	logic              grant;

	// effective unit count, clamped to 1..DEPTH
	always_comb begin
		if (unit_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (unit_count_q > DEPTH_C) begin
			n_eff = DEPTH_C;
		end else begin
			n_eff = unit_count_q;
		end
	end

	// scan start falls back to unit 0 when past the end
	assign start_ptr = (CNT_W'(ptr_q) < n_eff) ? ptr_q : '0;

	// free, free-at-or-after-start and done-or-unused vectors
	for (genvar p = 0; p < PAD_W; p++) begin : g_bits
		if (p < DEPTH) begin : g_used
			assign avail[p]     = (n_eff > CNT_W'(p)) && !done_map_q[p] && !busy_map_q[p];
			assign avail_hi[p]  = avail[p] && (CNT_W'(start_ptr) <= CNT_W'(p));
			assign done_mask[p] = done_map_q[p] || !(n_eff > CNT_W'(p));
		end else begin : g_pad
			assign avail[p]     = 1'b0;
			assign avail_hi[p]  = 1'b0;
			assign done_mask[p] = 1'b1;
		end
	end

	// group reductions
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			any_hi[g]   = |avail_hi[g*GROUP_W +: GROUP_W];
			any_all[g]  = |avail[g*GROUP_W +: GROUP_W];
			grp_done[g] = &done_mask[g*GROUP_W +: GROUP_W];
		end
	end

	// group pick: wrap to the full vector when nothing lies at or past the pointer
	assign use_hi  = |any_hi_s1;
	assign grp_vec = use_hi ? any_hi_s1 : any_all_s1;

	// bit pick inside the chosen group
	assign sel_vec   = use_hi_s2 ? avail_hi : avail;
	assign sel_bits  = sel_vec[grp_s2*GROUP_W +: GROUP_W];
	assign bit_sel   = first_set(sel_bits);
	assign unit_full = {grp_s2, bit_sel};
	assign unit_sel  = unit_full[IW-1:0];
	assign unit_next = CNT_W'(unit_sel) + CNT_W'(1);
	assign ptr_next  = (unit_next == n_eff) ? '0 : unit_next[IW-1:0];
	assign grant     = ctl.finish && (cmd_q == CMD_REQUEST) && found_s2;

	// mark command decode
	assign mark_cmd = (command == CMD_COMPLETE) || (command == CMD_FAIL);
	assign idx_ok   = CNT_W'(unit_index) < n_eff;
	assign mark_idx = unit_index[IW-1:0];

	// config register, bitmaps, pointer and done total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_count_q <= UNIT_COUNT_RST;
			done_map_q   <= '0;
			busy_map_q   <= '0;
			ptr_q        <= '0;
			done_total_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				unit_count_q <= cfg_wr_data;
			end
			if (ctl.load && mark_cmd && idx_ok) begin
				if (command == CMD_COMPLETE && !done_map_q[mark_idx]) begin
					done_map_q[mark_idx] <= 1'b1;
					done_total_q         <= done_total_q + CNT_W'(1);
				end
				busy_map_q[mark_idx] <= 1'b0;
			end
			if (grant) begin
				busy_map_q[unit_sel] <= 1'b1;
				ptr_q                <= ptr_next;
			end
		end
	end

	// per word pipeline and result registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q         <= command;
			mark_status_q <= (mark_cmd && !idx_ok) ? ST_RANGE : ST_OK;
		end
		if (ctl.sum) begin
			any_hi_s1   <= any_hi;
			any_all_s1  <= any_all;
			grp_done_s1 <= grp_done;
		end
		if (ctl.pick) begin
			grp_s2      <= first_set(grp_vec);
			use_hi_s2   <= use_hi;
			found_s2    <= |grp_vec;
			all_done_s2 <= &grp_done_s1;
		end
		if (ctl.finish) begin
			if (cmd_q == CMD_REQUEST) begin
				status_q  <= found_s2 ? ST_OK : ST_NONE;
				granted_q <= found_s2 ? IDX_W'(unit_sel) : '0;
			end else begin
				status_q  <= mark_status_q;
				granted_q <= '0;
			end
			done_count_q <= done_total_q;
			all_done_q   <= all_done_s2;
		end
	end

	assign status        = status_q;
	assign granted_index = granted_q;
	assign done_count    = done_count_q;
	assign all_done      = all_done_q;

endmodule

`default_nettype wire

### rtl/core/round_robin_piece_allocator.sv
// channel  | ports                                   | handshake
// command  | command, unit_index                     | taken when start high and busy low
// result   | status, granted_index, done_count,      | result_strobe high for one cycle,
//          | all_done                                |   no back pressure
// config   | cfg_wr_data                             | written when cfg_wr_en high
//
// every word runs a three step search from accept to the cycle its result shows:
// group sums, group pick, bit pick over 16 groups of 16 units
// a new word can be taken in the cycle its predecessor's result is shown
// marks hit the bitmaps at the accept edge, grants at the last step
// reset clears both bitmaps, the pointer and the done count at once
`timescale 1ns / 1ps
`default_nettype none

module round_robin_piece_allocator #(
	parameter int MAX_UNITS = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rra_pkg::CMD_W-1:0]     command,
	input  wire logic [rra_pkg::IDX_W-1:0]     unit_index,
	output logic                               result_strobe,
	output logic      [rra_pkg::STAT_W-1:0]    status,
	output logic      [rra_pkg::IDX_W-1:0]     granted_index,
	output logic      [rra_pkg::CNT_W-1:0]     done_count,
	output logic                               all_done,
	input  wire logic                          cfg_wr_en,
	input  wire logic [rra_pkg::CNT_W-1:0]     cfg_wr_data
);
	import rra_pkg::*;

	// bitmap depth: never more units than the index field can name
	localparam int DEPTH = (MAX_UNITS < PAD_W) ? MAX_UNITS : PAD_W;

	ctl_t ctl;

	// sequencer
	rra_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.result_strobe (result_strobe),
		.ctl           (ctl)
	);

	// bitmaps and search
	rra_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.command       (command),
		.unit_index    (unit_index),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.status        (status),
		.granted_index (granted_index),
		.done_count    (done_count),
		.all_done      (all_done)
	);

endmodule

`default_nettype wire

### verif/round_robin_piece_allocator_tb.sv
`timescale 1ns / 1ps

module round_robin_piece_allocator_tb;
	import rra_pkg::*;

	// command code the block leaves undefined
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int UNIT_SLOTS    = 256;
	localparam int SETTLE_CYCLES = 8;
	localparam int PRINT_CAP     = 100;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  granted;
		logic [CNT_W-1:0]  done_count;
		logic              all_done;
	} alloc_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [CMD_W-1:0]  command = CMD_REQUEST;
	logic [IDX_W-1:0]  unit_index = '0;
	logic              result_strobe;
	logic [STAT_W-1:0] status;
	logic [IDX_W-1:0]  granted_index;
	logic [CNT_W-1:0]  done_count;
	logic              all_done;
	logic              cfg_wr_en = 1'b0;
	logic [CNT_W-1:0]  cfg_wr_data = '0;

	// mirror of the allocator state
	bit               done_bits [UNIT_SLOTS];
	bit               taken_bits [UNIT_SLOTS];
	logic [IDX_W-1:0] scan_ptr = '0;
	logic [CNT_W-1:0] done_tally = '0;
	logic [CNT_W-1:0] unit_limit = UNIT_COUNT_RST;

	alloc_result_t pending_results[$];
	int            held_units[$];
	int            mismatch_count = 0;
	int            burst_left = 0;

	always #2 clk = ~clk;

	round_robin_piece_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.unit_index    (unit_index),
		.result_strobe (result_strobe),
		.status        (status),
		.granted_index (granted_index),
		.done_count    (done_count),
		.all_done      (all_done),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	// unit count after saturation to 1..256
	function automatic int active_units();
		int n;
		n = unit_limit;
		if (n < 1) n = 1;
		if (n > UNIT_SLOTS) n = UNIT_SLOTS;
		return n;
	endfunction

	// apply one word to the mirror and work out its result
	function automatic alloc_result_t predict_word(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] idx);
		alloc_result_t r;
		int n;
		int first;
		int u;
		bit found;
		n = active_units();
		r = '0;
		r.status = ST_OK;
		found = 1'b0;
		if (cmd == CMD_REQUEST) begin
			// pointer left past the end by a count change starts over at unit 0
			first = (scan_ptr < n) ? scan_ptr : 0;
			r.status = ST_NONE;
			for (int i = 0; i < n && !found; i++) begin
				u = first + i;
				if (u >= n) u -= n;
				if (!done_bits[u] && !taken_bits[u]) begin
					taken_bits[u] = 1'b1;
					scan_ptr = IDX_W'((u + 1) % n);
					r.granted = IDX_W'(u);
					r.status = ST_OK;
					found = 1'b1;
				end
			end
		end else if (cmd == CMD_COMPLETE || cmd == CMD_FAIL) begin
			if (idx >= n) begin
				r.status = ST_RANGE;
			end else begin
				// a repeated complete only clears the in-progress bit
				if (cmd == CMD_COMPLETE && !done_bits[idx]) begin
					done_bits[idx] = 1'b1;
					done_tally = done_tally + 1'b1;
				end
				taken_bits[idx] = 1'b0;
			end
		end
		r.done_count = done_tally;
		r.all_done = 1'b1;
		for (int i = 0; i < n; i++) begin
			if (!done_bits[i]) r.all_done = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP) begin
			$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		end
	endtask

	// compare every result word with the oldest pending one
	always @(posedge clk) begin : check_results
		alloc_result_t want;
		if (arst_n && result_strobe) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no word pending", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", status, want.status);
				if (granted_index !== want.granted)
					report_mismatch("granted_index", granted_index, want.granted);
				if (done_count !== want.done_count)
					report_mismatch("done_count", done_count, want.done_count);
				if (all_done !== want.all_done)
					report_mismatch("all_done", all_done, want.all_done);
			end
		end
	end

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// send one word, then keep the burst going or fall idle for a while
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			output alloc_result_t r);
		int gap;
		start <= 1'b1;
		command <= cmd;
		unit_index <= idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = predict_word(cmd, idx);
		pending_results.push_back(r);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			if ($urandom_range(0, 29) == 0) wait_drained();
			gap = $urandom_range(1, 7);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 8);
		end
	endtask

	// count register is written only with the block idle
	task automatic write_unit_count(input int value);
		start <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CNT_W'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		unit_limit = CNT_W'(value);
		held_units.delete();
	endtask

	// grants and marks at the reset count
	task automatic test_grant_and_marks();
		alloc_result_t r;
		send_word(CMD_REQUEST, 8'hff, r);
		send_word(CMD_REQUEST, 8'h00, r);
		send_word(CMD_COMPLETE, 8'd1, r);
		send_word(CMD_COMPLETE, 8'd1, r);
		send_word(CMD_FAIL, 8'd0, r);
		send_word(CMD_REQUEST, 8'h5a, r);
		send_word(CMD_COMPLETE, 8'd255, r);
		send_word(CMD_FAIL, 8'd255, r);
		send_word(CMD_UNUSED, 8'd255, r);
		send_word(CMD_FAIL, 8'd0, r);
	endtask

	// smallest and saturated counts, pointer past the end, out of range marks
	task automatic test_count_extremes();
		alloc_result_t r;
		write_unit_count(2);
		send_word(CMD_REQUEST, 8'h00, r);
		send_word(CMD_REQUEST, 8'h00, r);
		send_word(CMD_COMPLETE, 8'd2, r);
		send_word(CMD_FAIL, 8'd255, r);
		send_word(CMD_COMPLETE, 8'd0, r);
		send_word(CMD_REQUEST, 8'h00, r);
		write_unit_count(0);
		send_word(CMD_REQUEST, 8'h00, r);
		send_word(CMD_COMPLETE, 8'd0, r);
		send_word(CMD_FAIL, 8'd1, r);
		write_unit_count(511);
		send_word(CMD_REQUEST, 8'h00, r);
		send_word(CMD_COMPLETE, 8'd255, r);
		send_word(CMD_UNUSED, 8'd0, r);
	endtask

	// request then complete or fail of held units, with some noise words
	task automatic run_traffic_phase(input int count_value, input int words,
			input int complete_pct);
		alloc_result_t r;
		int n;
		int k;
		int roll;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		write_unit_count(count_value);
		n = active_units();
		repeat (words) begin
			roll = $urandom_range(0, 99);
			if (roll < 12) begin
				cmd = CMD_W'($urandom_range(0, 3));
				idx = $urandom_range(0, 1) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, n - 1));
				send_word(cmd, idx, r);
			end else if (held_units.size() > 0 && (roll < 55 || held_units.size() > 6)) begin
				k = $urandom_range(0, held_units.size() - 1);
				idx = IDX_W'(held_units[k]);
				held_units.delete(k);
				cmd = ($urandom_range(0, 99) < complete_pct) ? CMD_COMPLETE : CMD_FAIL;
				send_word(cmd, idx, r);
			end else begin
				send_word(CMD_REQUEST, IDX_W'($urandom), r);
				if (r.status == ST_OK) held_units.push_back(r.granted);
			end
		end
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(2, 60, 50);
		run_traffic_phase($urandom_range(3, 40), 200, 30);
		run_traffic_phase($urandom_range(41, 128), 250, 30);
		run_traffic_phase(17, 150, 40);
		run_traffic_phase(255, 300, 40);
		run_traffic_phase(256, 350, 40);
		run_traffic_phase(0, 30, 50);
		run_traffic_phase(511, 400, 95);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_grant_and_marks();
		test_count_extremes();
		test_random_traffic();
		start <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("round_robin_piece_allocator_tb OK");
		end else begin
			$display("round_robin_piece_allocator_tb NOT OK");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("round_robin_piece_allocator_tb NOT OK");
		$finish;
	end

endmodule

### filelist.f
rtl/core/rra_pkg.sv
rtl/core/rra_ctrl.sv
rtl/core/rra_datapath.sv
rtl/core/round_robin_piece_allocator.sv
verif/round_robin_piece_allocator_tb.sv
